// ===== hw/rtl/gfq_pkg.sv =====
// gfq_pkg: shared types, sizes and op codes for the grouped fifo queue
// no dependencies
package gfq_pkg;
	localparam int MEMBER_IDS  = 1024;
	localparam int GROUPS      = 32;
	localparam int GROUP_DEPTH = 64;
	localparam int MW = $clog2(MEMBER_IDS);
	localparam int GW = $clog2(GROUPS);
	localparam int DW = $clog2(GROUP_DEPTH);
	localparam int SW = GW + DW;

	typedef enum logic [1:0] {
		OP_ASSIGN = 2'd0,
		OP_ENQ    = 2'd1,
		OP_DEQ    = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [9:0]  member_id;
		logic [4:0]  group_id;
	} in_item_t;

	typedef struct packed {
		logic [9:0]  member_out;
		logic        out_valid;
		logic [1:0]  status;
	} out_item_t;

	// classified command from front to back
	typedef struct packed {
		op_t          op;
		logic [MW-1:0] mid;
		logic [GW-1:0] grp;
	} cmd_t;
endpackage

// ===== hw/rtl/gfq_ram.sv =====
// gfq_ram: generic single-port-write, one-read ram with registered read
// no dependencies
module gfq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end
endmodule

// ===== hw/rtl/gfq_front.sv =====
// gfq_front: accepts items, owns the member table, resolves each item's group
// depends on gfq_pkg, gfq_ram
module gfq_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  gfq_pkg::in_item_t  in_item,
	output logic               cmd_valid,
	input  logic               cmd_stall,
	output gfq_pkg::cmd_t      cmd
);
	logic                   busy_q;
	logic [gfq_pkg::GW-1:0] tbl_rd;
	gfq_pkg::cmd_t          pend_q;
	logic                   clr_q;
	logic [gfq_pkg::MW:0]   clr_cnt_q;
	logic                   acc;
	logic                   wr_en;
	logic [gfq_pkg::MW-1:0] wr_addr;
	logic [gfq_pkg::GW-1:0] wr_data;
	logic                   mid_ok;
	logic                   gid_ok;
	logic                   mid_ok_q;

	// member table clears after reset, one entry a cycle
	assign in_stall = busy_q || clr_q;
	assign acc = in_valid && !in_stall;
	assign mid_ok = ({22'd0, in_item.member_id} < gfq_pkg::MEMBER_IDS);
	assign gid_ok = ({27'd0, in_item.group_id} < gfq_pkg::GROUPS);

	always_comb begin
		wr_en = 1'b0;
		wr_addr = in_item.member_id[gfq_pkg::MW-1:0];
		wr_data = in_item.group_id[gfq_pkg::GW-1:0];
		if (clr_q) begin
			wr_en = 1'b1;
			wr_addr = clr_cnt_q[gfq_pkg::MW-1:0];
			wr_data = '0;
		end else if (acc && gfq_pkg::op_t'(in_item.op) == gfq_pkg::OP_ASSIGN
				&& mid_ok && gid_ok) begin
			wr_en = 1'b1;
		end
	end

	gfq_ram #(.WIDTH(gfq_pkg::GW), .DEPTH(gfq_pkg::MEMBER_IDS)) u_tbl (
		.clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(wr_data),
		.re(acc), .raddr(in_item.member_id[gfq_pkg::MW-1:0]), .rdata(tbl_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			clr_q <= 1'b1;
			clr_cnt_q <= '0;
		end else begin
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == (gfq_pkg::MW+1)'(gfq_pkg::MEMBER_IDS - 1)) clr_q <= 1'b0;
			end
			if (acc) busy_q <= 1'b1;
			else if (busy_q && !cmd_stall) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pend_q.op <= gfq_pkg::op_t'(in_item.op);
			pend_q.mid <= in_item.member_id[gfq_pkg::MW-1:0];
			pend_q.grp <= '0;
		end
	end

	assign cmd_valid = busy_q;
	always_comb begin
		cmd = pend_q;
		if (mid_ok_q) cmd.grp = tbl_rd;
		else cmd.grp = '0;
	end

	always_ff @(posedge clk) begin
		if (acc) mid_ok_q <= mid_ok;
	end
endmodule

// ===== hw/rtl/gfq_back.sv =====
// gfq_back: group fifos and order fifo, executes classified commands
// depends on gfq_pkg, gfq_ram
module gfq_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  gfq_pkg::cmd_t      cmd,
	output logic               out_valid,
	input  logic               out_stall,
	output gfq_pkg::out_item_t out_item
);
	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_READ = 3'b010,
		S_OUT  = 3'b100
	} state_t;

	state_t state_q;
	logic [gfq_pkg::DW-1:0] head_q  [gfq_pkg::GROUPS];
	logic [gfq_pkg::DW:0]   count_q [gfq_pkg::GROUPS];
	logic [gfq_pkg::GROUPS-1:0] wait_q;
	logic [gfq_pkg::GW-1:0] order_q [gfq_pkg::GROUPS];
	logic [gfq_pkg::GW-1:0] ohead_q;
	logic [gfq_pkg::GW:0]   ocount_q;
	logic [gfq_pkg::MW-1:0] st_rd;
	logic                   st_we;
	logic [gfq_pkg::SW-1:0] st_wa;
	logic                   st_re;
	logic [gfq_pkg::SW-1:0] st_ra;
	logic                   take;
	logic [gfq_pkg::GW-1:0] g;
	logic [gfq_pkg::GW-1:0] og;
	logic [gfq_pkg::DW-1:0] slot;
	logic                   full;
	logic                   deq_ok;
	gfq_pkg::out_item_t     res_nxt;
	gfq_pkg::out_item_t     res_q;

	assign cmd_stall = (state_q != S_IDLE);
	assign take = cmd_valid && !cmd_stall;
	assign g = cmd.grp;
	assign og = order_q[ohead_q];
	assign full = (count_q[g] >= (gfq_pkg::DW+1)'(gfq_pkg::GROUP_DEPTH));
	// slot wraps naturally since depth is a power of two
	assign slot = head_q[g] + count_q[g][gfq_pkg::DW-1:0];
	assign deq_ok = (ocount_q != '0) && (count_q[og] != '0);
	assign st_we = take && cmd.op == gfq_pkg::OP_ENQ && !full;
	assign st_wa = {g, slot};
	assign st_re = take && cmd.op == gfq_pkg::OP_DEQ && deq_ok;
	assign st_ra = {og, head_q[og]};

	gfq_ram #(.WIDTH(gfq_pkg::MW), .DEPTH(gfq_pkg::GROUPS*gfq_pkg::GROUP_DEPTH)) u_st (
		.clk(clk), .we(st_we), .waddr(st_wa), .wdata(cmd.mid),
		.re(st_re), .raddr(st_ra), .rdata(st_rd)
	);

	always_comb begin
		res_nxt = '0;
		if (cmd.op == gfq_pkg::OP_ENQ && full) res_nxt.status = gfq_pkg::ST_FULL;
		if (cmd.op == gfq_pkg::OP_DEQ) begin
			if (deq_ok) res_nxt.out_valid = 1'b1;
			else res_nxt.status = gfq_pkg::ST_EMPTY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wait_q <= '0;
			ohead_q <= '0;
			ocount_q <= '0;
			for (int i = 0; i < gfq_pkg::GROUPS; i++) begin
				head_q[i] <= '0;
				count_q[i] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: if (take) begin
					state_q <= S_OUT;
					case (cmd.op)
						gfq_pkg::OP_ENQ: if (!full) begin
							count_q[g] <= count_q[g] + 1'b1;
							if (!wait_q[g] && ocount_q < (gfq_pkg::GW+1)'(gfq_pkg::GROUPS)) begin
								wait_q[g] <= 1'b1;
								ocount_q <= ocount_q + 1'b1;
							end
						end
						gfq_pkg::OP_DEQ: if (deq_ok) begin
							state_q <= S_READ;
							head_q[og] <= head_q[og] + 1'b1;
							count_q[og] <= count_q[og] - 1'b1;
							if (count_q[og] == (gfq_pkg::DW+1)'(1)) begin
								wait_q[og] <= 1'b0;
								ohead_q <= ohead_q + 1'b1;
								ocount_q <= ocount_q - 1'b1;
							end
						end
						gfq_pkg::OP_CLEAR: begin
							wait_q <= '0;
							ohead_q <= '0;
							ocount_q <= '0;
							for (int i = 0; i < gfq_pkg::GROUPS; i++) begin
								head_q[i] <= '0;
								count_q[i] <= '0;
							end
						end
						default: ;
					endcase
				end
				S_READ: state_q <= S_OUT;
				S_OUT: if (!out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_nxt;
			// order slot written at tail
			if (cmd.op == gfq_pkg::OP_ENQ && !full && !wait_q[g]
					&& ocount_q < (gfq_pkg::GW+1)'(gfq_pkg::GROUPS))
				order_q[ohead_q + ocount_q[gfq_pkg::GW-1:0]] <= g;
		end else if (state_q == S_READ) begin
			res_q.member_out <= st_rd;
		end
	end

	assign out_valid = (state_q == S_OUT);
	assign out_item = res_q;
endmodule

// ===== hw/rtl/grouped_fifo_queue.sv =====
// grouped_fifo_queue: team queue top level
// depends on gfq_pkg, gfq_front, gfq_back
//
//  channel | signals                    | payload
//  in      | in_valid / in_stall        | gfq_pkg::in_item_t
//  out     | out_valid / out_stall      | gfq_pkg::out_item_t
//
// an item passes through a member table read in the front, then the
// group fifo update and, for a dequeue, a registered store read in the back.
// the front can take the next item while the back still works on one.
// after reset all 1024 member table entries are cleared, input stalled.
// output stall holds the result and backs up through the command register.
module grouped_fifo_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  gfq_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output gfq_pkg::out_item_t out_item
);
	logic          cmd_valid;
	logic          cmd_stall;
	gfq_pkg::cmd_t cmd;

	gfq_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_item(in_item), .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd)
	);

	gfq_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
		.cmd(cmd), .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
	);
endmodule

// ===== hw/rtl/gfq_checker.sv =====
// gfq_checker: port-level checks for grouped_fifo_queue, bound to the top
// depends on gfq_pkg
module gfq_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input gfq_pkg::in_item_t  in_item,
	input logic               out_valid,
	input logic               out_stall,
	input gfq_pkg::out_item_t out_item
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");
	a_vld: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.out_valid |-> out_item.status == gfq_pkg::ST_OK)
		else $error("member with error status");
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.status <= gfq_pkg::ST_FULL)
		else $error("bad status code");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accept");
endmodule

bind grouped_fifo_queue gfq_checker u_chk (.*);
